// ----- design/assert_macros.svh -----
// Assertion macros for the hash table RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DHT_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DHT_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define DHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- design/dht_pkg.sv -----
// Shared types and constants for the double hashing table.
// No dependencies; used by the controller, the datapath and the top level.
package dht_pkg;

  localparam int DHT_TABLE_SIZE  = 256;
  localparam int DHT_VALUE_WIDTH = 32;

  localparam int KEY_W = 31;
  localparam int CMD_W = 2;

  // Operation codes.
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOK = 2'd2;

  // The probe step is STEP_MOD minus the key modulo STEP_MOD.
  localparam logic [3:0]  STEP_MOD = 4'd13;
  // Reciprocal of STEP_MOD scaled by 2**S13; the quotient estimate is low by at most one.
  localparam int          S13      = 35;
  localparam logic [31:0] M13      = 32'((64'd1 << S13) / 64'd13);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic load;
    logic probe_start;
    logic probe_run;
    logic commit;
  } dht_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic chk_valid;
    logic iss_valid;
    logic hit;
    logic stop;
  } dht_stat_t;

endpackage

// ----- design/dht_ctrl.sv -----
// Controller state machine of the double hashing table.
// Depends on dht_pkg for the command and status structs.
module dht_ctrl import dht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output logic      out_ok,
  output dht_ctrl_t ctrl_o,
  input  dht_stat_t stat_i
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_H1    = 7'b0000100,
    S_H2    = 7'b0001000,
    S_H3    = 7'b0010000,
    S_PROBE = 7'b0100000,
    S_DONE  = 7'b1000000
  } dht_state_t;

  dht_state_t state_r, state_nxt;
  logic       ok_r, ok_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_ok_r, out_ok_nxt;

  always_comb begin
    state_nxt     = state_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    ctrl_o        = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        ctrl_o.clear_en = 1'b1;
        if (stat_i.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctrl_o.load = 1'b1;
          state_nxt   = S_H1;
        end
      end
      S_H1: state_nxt = S_H2;
      S_H2: state_nxt = S_H3;
      S_H3: begin
        ctrl_o.probe_start = 1'b1;
        state_nxt          = S_PROBE;
      end
      S_PROBE: begin
        ctrl_o.probe_run = 1'b1;
        if (stat_i.hit) begin
          ctrl_o.commit = 1'b1;
          ok_nxt        = 1'b1;
          state_nxt     = S_DONE;
        end else if (stat_i.stop || (!stat_i.chk_valid && !stat_i.iss_valid)) begin
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r     <= ok_nxt;
    out_ok_r <= out_ok_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;

endmodule

// ----- design/dht_dp.sv -----
// Datapath of the double hashing table: hash pipeline, probe walker and slot memories.
// Depends on dht_pkg and on assert_macros.svh for its checks.
`include "assert_macros.svh"

module dht_dp import dht_pkg::*; #(
  parameter int TABLE_SIZE  = DHT_TABLE_SIZE,
  parameter int VALUE_WIDTH = DHT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [CMD_W-1:0]       in_cmd,
  input  logic [KEY_W-1:0]       in_entry_key,
  input  logic [VALUE_WIDTH-1:0] in_entry_value,
  input  dht_ctrl_t              ctrl_i,
  output dht_stat_t              stat_o
);

  localparam int AW   = $clog2(TABLE_SIZE);
  localparam int S_TS = KEY_W + AW;
  localparam longint unsigned M_TS_L = (64'd1 << S_TS) / TABLE_SIZE;
  localparam logic [31:0] M_TS_W = 32'(M_TS_L);
  localparam logic [31:0] TS_W   = 32'(TABLE_SIZE);
  localparam logic [AW:0] TS_E   = (AW+1)'(TABLE_SIZE);
  localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

  // Request registers.
  logic [CMD_W-1:0]       cmd_r;
  logic [KEY_W-1:0]       key_r;
  logic [VALUE_WIDTH-1:0] val_r;

  // Hash pipeline.
  logic [62:0] prod_ts_r, prod_ts_nxt;
  logic [62:0] prod_13_r, prod_13_nxt;
  logic [31:0] qts_r, qts_nxt;
  logic [31:0] q13x_r, q13x_nxt;
  logic [KEY_W-1:0] q_ts, q_13;
  logic [31:0] r_ts, r_ts_c, r_13, r_13_c, step_w;
  logic [AW-1:0] start_c;
  logic [3:0]    step_c;

  // Probe walker.
  logic [AW-1:0] start_r, iss_pos_r, chk_pos_r, clr_addr_r, nxt_pos;
  logic [3:0]    step_r;
  logic          iss_valid_r, chk_valid_r;
  logic [AW:0]   sum;

  // Slot memories and their registered read data.
  logic [1:0]             flag_mem [TABLE_SIZE];
  logic [KEY_W-1:0]       key_mem  [TABLE_SIZE];
  logic [VALUE_WIDTH-1:0] val_mem  [TABLE_SIZE];
  logic [1:0]             flag_rd_r;
  logic [KEY_W-1:0]       key_rd_r;
  logic [VALUE_WIDTH-1:0] val_rd_r;

  logic          flag_we, kv_we;
  logic [AW-1:0] flag_wa;
  logic [1:0]    flag_wd;
  logic          live, tomb, key_eq, val_eq, hit_c, stop_c;

  always_ff @(posedge clk) begin
    if (ctrl_i.load) begin
      cmd_r <= in_cmd;
      key_r <= in_entry_key;
      val_r <= in_entry_value;
    end
  end

  // Both remainders come from a reciprocal multiply, a multiply back and one correction.
  assign prod_ts_nxt = {32'd0, key_r} * {31'd0, M_TS_W};
  assign prod_13_nxt = {32'd0, key_r} * {31'd0, M13};
  assign q_ts        = KEY_W'(prod_ts_r >> S_TS);
  assign q_13        = KEY_W'(prod_13_r >> S13);
  assign qts_nxt     = {1'b0, q_ts} * TS_W;
  assign q13x_nxt    = {1'b0, q_13} * {28'd0, STEP_MOD};

  always_ff @(posedge clk) begin
    prod_ts_r <= prod_ts_nxt;
    prod_13_r <= prod_13_nxt;
    qts_r     <= qts_nxt;
    q13x_r    <= q13x_nxt;
  end

  always_comb begin
    r_ts    = {1'b0, key_r} - qts_r;
    r_ts_c  = (r_ts >= TS_W) ? (r_ts - TS_W) : r_ts;
    start_c = r_ts_c[AW-1:0];
    r_13    = {1'b0, key_r} - q13x_r;
    r_13_c  = (r_13 >= {28'd0, STEP_MOD}) ? (r_13 - {28'd0, STEP_MOD}) : r_13;
    step_w  = {28'd0, STEP_MOD} - r_13_c;
    step_c  = step_w[3:0];
  end

  // Next slot on the probe sequence, wrapping once around the table.
  always_comb begin
    sum     = (AW+1)'(iss_pos_r) + (AW+1)'(step_r);
    nxt_pos = (sum >= TS_E) ? AW'(sum - TS_E) : sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_valid_r <= 1'b0;
      chk_valid_r <= 1'b0;
      clr_addr_r  <= '0;
    end else begin
      if (ctrl_i.clear_en) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (ctrl_i.probe_start) begin
        iss_valid_r <= 1'b1;
        chk_valid_r <= 1'b0;
      end else if (ctrl_i.probe_run) begin
        chk_valid_r <= iss_valid_r;
        if (nxt_pos == start_r) begin
          iss_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.probe_start) begin
      start_r   <= start_c;
      iss_pos_r <= start_c;
      step_r    <= step_c;
    end else if (ctrl_i.probe_run) begin
      chk_pos_r <= iss_pos_r;
      iss_pos_r <= nxt_pos;
    end
  end

  // Flag writes: clearing pass, a new entry, or a tombstone.
  always_comb begin
    flag_we = 1'b0;
    flag_wa = chk_pos_r;
    flag_wd = 2'b00;
    kv_we   = 1'b0;
    if (ctrl_i.clear_en) begin
      flag_we = 1'b1;
      flag_wa = clr_addr_r;
    end else if (ctrl_i.commit) begin
      case (cmd_r)
        CMD_ADD: begin
          flag_we = 1'b1;
          flag_wd = 2'b10;
          kv_we   = 1'b1;
        end
        CMD_DEL: begin
          flag_we = 1'b1;
          flag_wd = 2'b01;
        end
        default: flag_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_wa] <= flag_wd;
    end
    flag_rd_r <= flag_mem[iss_pos_r];
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[chk_pos_r] <= key_r;
      val_mem[chk_pos_r] <= val_r;
    end
    key_rd_r <= key_mem[iss_pos_r];
    val_rd_r <= val_mem[iss_pos_r];
  end

  // Slot evaluation. Key and value are only looked at in live slots.
  always_comb begin
    live   = flag_rd_r[1];
    tomb   = flag_rd_r[0];
    key_eq = (key_rd_r == key_r);
    val_eq = (val_rd_r == val_r);
    hit_c  = 1'b0;
    stop_c = 1'b0;
    case (cmd_r)
      CMD_ADD: begin
        hit_c  = !live;
        stop_c = live && key_eq;
      end
      CMD_DEL, CMD_LOOK: begin
        hit_c  = live && key_eq && val_eq;
        stop_c = !live && !tomb;
      end
      default: stop_c = 1'b1;
    endcase
  end

  assign stat_o.clear_last = (clr_addr_r == LAST);
  assign stat_o.chk_valid  = chk_valid_r;
  assign stat_o.iss_valid  = iss_valid_r;
  assign stat_o.hit        = chk_valid_r && hit_c;
  assign stat_o.stop       = chk_valid_r && stop_c;

  `DHT_ASSERT(a_commit_chk, clk, rst_n, ctrl_i.commit, chk_valid_r, "commit without a checked slot")
  `DHT_ASSERT(a_clear_excl, clk, rst_n, ctrl_i.clear_en, !ctrl_i.commit && !ctrl_i.load, "request activity during the clearing pass")
  `DHT_ASSERT_NXT(a_step_rng, clk, rst_n, ctrl_i.probe_start, (step_r != 4'd0) && (step_r <= STEP_MOD), "probe step out of range")
  `DHT_ASSERT(a_pos_rng, clk, rst_n, iss_valid_r, (AW+1)'(iss_pos_r) < TS_E, "probe slot beyond the table")

endmodule

// ----- design/double_hash_table.sv -----
// Top level of the open-addressing hash table with double hashing.
// Depends on dht_pkg, dht_ctrl and dht_dp.
//
// Channel  Ports                                        Direction  Carries
// in       in_valid in_ready in_cmd in_entry_key ...    sink       one add, delete or lookup
// out      out_valid out_ready out_ok                   source     one ok bit per request
//
// An accepted request passes through the hash states H1, H2 and H3, the probe state
// and the done state; the probe walker reads one slot per cycle from the slot memory.
// After reset the block clears every slot flag before in_ready rises.
// A result waiting on out_ready holds the block in its final state; the output register
// itself still lets the next request be accepted while an earlier result waits.
module double_hash_table import dht_pkg::*; #(
  parameter int TABLE_SIZE  = DHT_TABLE_SIZE,
  parameter int VALUE_WIDTH = DHT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CMD_W-1:0]       in_cmd,
  input  logic [KEY_W-1:0]       in_entry_key,
  input  logic [VALUE_WIDTH-1:0] in_entry_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_ok
);

  // The controller sequences hashing, probing and the response; the datapath
  // holds the request, the slot memories and the probe position.
  dht_ctrl_t ctrl;
  dht_stat_t stat;

  dht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ok    (out_ok),
    .ctrl_o    (ctrl),
    .stat_i    (stat)
  );

  // Slot search: start at key mod TABLE_SIZE and step by 13 minus key mod 13,
  // stopping on a decisive slot or when the sequence returns to its start.
  dht_dp #(
    .TABLE_SIZE  (TABLE_SIZE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_cmd),
    .in_entry_key   (in_entry_key),
    .in_entry_value (in_entry_value),
    .ctrl_i         (ctrl),
    .stat_o         (stat)
  );

endmodule

// ----- tb/sv/double_hash_table_test.sv -----
// Self-checking testbench for the double hashing table: directed, crowded-class,
// back-pressure and random request streams, checked against an in-bench table model.
// Depends on dht_pkg and the double_hash_table RTL only.
`timescale 1ns / 100ps

module double_hash_table_test;
  import dht_pkg::*;

  // Command code that the block must ignore.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // The slowest request walks all 256 slots; the wait bounds below leave room for that.
  localparam int          SETTLE_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int          HOLD_CYCLES   = 400;

  // One accepted request together with the ok bit the table model predicts for it.
  typedef struct {
    logic [CMD_W-1:0]           cmd;
    logic [KEY_W-1:0]           key;
    logic [DHT_VALUE_WIDTH-1:0] value;
    logic                       ok;
  } table_reply_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [CMD_W-1:0]           in_cmd;
  logic [KEY_W-1:0]           in_entry_key;
  logic [DHT_VALUE_WIDTH-1:0] in_entry_value;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_ok;

  double_hash_table dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_entry_key  (in_entry_key),
    .in_entry_value(in_entry_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ok        (out_ok)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Table model: keys, values, live and tombstone flags. Keys and values are only read
  // from live slots, so their contents before the first write never matter.
  logic [KEY_W-1:0]           model_key   [DHT_TABLE_SIZE];
  logic [DHT_VALUE_WIDTH-1:0] model_value [DHT_TABLE_SIZE];
  bit                         model_live  [DHT_TABLE_SIZE];
  bit                         model_tomb  [DHT_TABLE_SIZE];

  // Expected ok bits, oldest first.
  table_reply_t pending_ok[$];

  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned results_checked;
  int unsigned add_count, delete_count, lookup_count, unused_count;
  int unsigned success_count, exhausted_count;

  // Traffic shaping shared by the sender, the receiver and the tests.
  bit          no_gaps;
  bit          no_stalls;
  int unsigned hold_off_request;

  // Random request pool used by the random test; hot start slots make probes collide.
  logic [KEY_W-1:0]           pool_key   [48];
  logic [DHT_VALUE_WIDTH-1:0] pool_value [48];

  // Most gaps are zero or short; now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Half the keys land on one of eight hot start slots, the rest anywhere.
  function automatic logic [KEY_W-1:0] make_key();
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(0, 1) != 0)
      return raw[KEY_W-1:0];
    return {raw[KEY_W-1:8], 8'($urandom_range(0, 7) * 32 + 5)};
  endfunction

  // Add: store in the first slot that is not live, unless a live slot with the same
  // key turns up first.
  function automatic bit model_add(logic [KEY_W-1:0] key, logic [DHT_VALUE_WIDTH-1:0] value);
    int unsigned first;
    int unsigned stride;
    int unsigned pos;
    first  = int'(key) % DHT_TABLE_SIZE;
    stride = int'(STEP_MOD) - int'(key) % int'(STEP_MOD);
    pos    = first;
    for (int n = 0; n < DHT_TABLE_SIZE; n++) begin
      if (!model_live[pos]) begin
        model_key[pos]   = key;
        model_value[pos] = value;
        model_live[pos]  = 1'b1;
        model_tomb[pos]  = 1'b0;
        return 1'b1;
      end
      if (model_key[pos] == key) return 1'b0;
      pos = (pos + stride) % DHT_TABLE_SIZE;
      if (pos == first) break;
    end
    exhausted_count++;
    return 1'b0;
  endfunction

  // Delete and lookup: walk past tombstones, stop at a never-used slot, and match a
  // live slot on both key and value. A delete leaves a tombstone behind.
  function automatic bit model_match(logic [KEY_W-1:0] key, logic [DHT_VALUE_WIDTH-1:0] value,
                                     bit remove);
    int unsigned first;
    int unsigned stride;
    int unsigned pos;
    first  = int'(key) % DHT_TABLE_SIZE;
    stride = int'(STEP_MOD) - int'(key) % int'(STEP_MOD);
    pos    = first;
    for (int n = 0; n < DHT_TABLE_SIZE; n++) begin
      if (!model_live[pos] && !model_tomb[pos]) return 1'b0;
      if (model_live[pos] && model_key[pos] == key && model_value[pos] == value) begin
        if (remove) begin
          model_live[pos] = 1'b0;
          model_tomb[pos] = 1'b1;
        end
        return 1'b1;
      end
      pos = (pos + stride) % DHT_TABLE_SIZE;
      if (pos == first) break;
    end
    exhausted_count++;
    return 1'b0;
  endfunction

  function automatic logic table_apply(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                       logic [DHT_VALUE_WIDTH-1:0] value);
    logic ok;
    case (cmd)
      CMD_ADD: begin
        add_count++;
        ok = model_add(key, value);
      end
      CMD_DEL: begin
        delete_count++;
        ok = model_match(key, value, 1'b1);
      end
      CMD_LOOK: begin
        lookup_count++;
        ok = model_match(key, value, 1'b0);
      end
      default: begin
        unused_count++;
        ok = 1'b0;
      end
    endcase
    if (ok) success_count++;
    return ok;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Offer one request after an optional idle gap and hold it until it is taken. The
  // model is updated at the accepting edge, so requests are predicted in block order.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                              logic [DHT_VALUE_WIDTH-1:0] value);
    int unsigned  gap;
    table_reply_t reply;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       = 1'b1;
    in_cmd         = cmd;
    in_entry_key   = key;
    in_entry_value = value;
    do @(posedge clk); while (!in_ready);
    reply.cmd   = cmd;
    reply.key   = key;
    reply.value = value;
    reply.ok    = table_apply(cmd, key, value);
    pending_ok.push_back(reply);
  endtask

  // The sender goes quiet until every outstanding request has been answered.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_ok.size() != 0) @(posedge clk);
  endtask

  // Result checker. Every handshake on the result side must pair with the oldest
  // outstanding request.
  always @(posedge clk) begin : check_result
    table_reply_t head;
    if (rst_n && out_valid && out_ready) begin
      if (pending_ok.size() == 0) begin
        note_failure($sformatf("result ok=%b with no request outstanding", out_ok));
      end else begin
        head = pending_ok.pop_front();
        results_checked++;
        if (out_ok !== head.ok)
          note_failure($sformatf("cmd %0d key 0x%08h value 0x%08h: expected ok=%b, got %b",
                                 head.cmd, head.key, head.value, head.ok, out_ok));
      end
    end
  end

  // Receiver. Random stalls unless asked to stay ready; a hold-off request keeps
  // out_ready low for the requested stretch so the block backs up into its input.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned held;
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_request != 0) begin
        out_ready = 1'b0;
        for (held = 0; held < hold_off_request; held++) @(negedge clk);
        hold_off_request = 0;
      end else if (stall_left != 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready  = 1'b1;
        stall_left = no_stalls ? 0 : pick_gap();
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Watchdog expired after %0d cycles, %0d requests still outstanding",
             cycle_count, pending_ok.size());
    $display("Some tests failed");
    $finish;
  end

  // Extremes of key and value, every command, and the unused command code. The table
  // starts empty, so the first lookup must stop at a never-used slot.
  task automatic test_basic_ops();
    logic [KEY_W-1:0]           key_max;
    logic [DHT_VALUE_WIDTH-1:0] value_max;
    key_max   = '1;
    value_max = '1;
    send_request(CMD_LOOK, '0, '0);
    send_request(CMD_ADD, '0, '0);
    send_request(CMD_LOOK, '0, '0);
    send_request(CMD_ADD, key_max, value_max);
    send_request(CMD_LOOK, key_max, value_max);
    send_request(CMD_LOOK, key_max, '0);
    // A second add of a live key fails even with a different value.
    send_request(CMD_ADD, key_max, 32'h5A5A_A5A5);
    send_request(CMD_DEL, key_max, 32'h7FFF_FFFF);
    send_request(CMD_DEL, key_max, value_max);
    send_request(CMD_LOOK, key_max, value_max);
    send_request(CMD_DEL, key_max, value_max);
    // The unused code must not store anything.
    send_request(CMD_UNUSED, 31'h2AAA_AAAA, 32'hAAAA_AAAA);
    send_request(CMD_LOOK, 31'h2AAA_AAAA, 32'hAAAA_AAAA);
    send_request(CMD_DEL, '0, '0);
    wait_idle();
  endtask

  // Two keys share a start slot. Once the first is deleted, adding the second again
  // stops at the tombstone and stores a duplicate ahead of the live copy.
  task automatic test_tombstone_duplicate();
    logic [KEY_W-1:0]           key_a, key_b;
    logic [DHT_VALUE_WIDTH-1:0] val_a, val_b;
    key_a = {23'h000001, 8'd77};
    key_b = {23'h000123, 8'd77};
    val_a = $urandom;
    val_b = $urandom;
    send_request(CMD_ADD, key_a, val_a);
    send_request(CMD_ADD, key_b, val_b);
    send_request(CMD_DEL, key_a, val_a);
    send_request(CMD_ADD, key_b, val_b);
    send_request(CMD_LOOK, key_b, val_b);
    send_request(CMD_DEL, key_b, val_b);
    send_request(CMD_LOOK, key_b, val_b);
    send_request(CMD_DEL, key_b, val_b);
    send_request(CMD_LOOK, key_b, val_b);
    wait_idle();
  endtask

  // Keys with key mod 13 equal to 5 step by 8, so their probe covers only the 32 slots
  // of one residue class mod 8 and wraps back to the start early. Filling that class
  // makes further adds and misses run the whole short cycle and give up.
  task automatic test_crowded_class();
    logic [KEY_W-1:0]           class_key   [40];
    logic [DHT_VALUE_WIDTH-1:0] class_value [40];
    int unsigned                residue;
    int unsigned                base;
    int unsigned                pick;
    residue = $urandom_range(0, 7);
    base    = 0;
    for (int r = 0; r < 104; r++)
      if (r % 13 == 5 && r % 8 == residue) base = r;
    // 104 = 13 * 8, so every key below keeps both residues.
    for (int i = 0; i < 40; i++) begin
      class_key[i]   = KEY_W'(104 * $urandom_range(0, 20_600_000) + base);
      class_value[i] = $urandom;
    end
    for (int i = 0; i < 36; i++) send_request(CMD_ADD, class_key[i], class_value[i]);
    for (int i = 0; i < 8; i++) begin
      pick = $urandom_range(0, 35);
      send_request(CMD_LOOK, class_key[pick], class_value[pick]);
    end
    for (int i = 36; i < 40; i++) send_request(CMD_LOOK, class_key[i], class_value[i]);
    for (int i = 0; i < 6; i++) send_request(CMD_DEL, class_key[i], class_value[i]);
    // Deleted entries leave tombstones that the next adds reuse; the deleted keys
    // are then missing from a class with no never-used slot left.
    for (int i = 36; i < 40; i++) send_request(CMD_ADD, class_key[i], class_value[i]);
    for (int i = 0; i < 3; i++) send_request(CMD_LOOK, class_key[i], class_value[i]);
    wait_idle();
  endtask

  // The receiver stops taking results for a long stretch while the sender keeps
  // offering back-to-back requests; the block must stall its input, not drop work.
  task automatic test_result_backpressure();
    logic [KEY_W-1:0]           key;
    logic [DHT_VALUE_WIDTH-1:0] value;
    no_gaps          = 1'b1;
    hold_off_request = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      key   = make_key();
      value = $urandom;
      send_request(i % 3 == 2 ? CMD_LOOK : CMD_ADD, key, value);
      if (i % 3 == 0) send_request(CMD_LOOK, key, value);
    end
    no_gaps = 1'b0;
    wait_idle();
  endtask

  // Random traffic in chunks. Most requests work a pool of keys so adds, deletes and
  // lookups meet each other; some carry a wrong value, a few are pure noise.
  task automatic test_random_traffic(int unsigned chunks);
    logic [CMD_W-1:0]           cmd;
    logic [KEY_W-1:0]           key;
    logic [DHT_VALUE_WIDTH-1:0] value;
    int unsigned                idx;
    int unsigned                roll;
    for (int i = 0; i < 48; i++) begin
      pool_key[i]   = make_key();
      pool_value[i] = $urandom;
    end
    for (int c = 0; c < chunks; c++) begin
      no_gaps   = (c == 0) || ($urandom_range(0, 3) == 0);
      no_stalls = (c == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 8; i++) begin
        idx             = $urandom_range(0, 47);
        pool_key[idx]   = make_key();
        pool_value[idx] = $urandom;
      end
      for (int n = 0; n < 50; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          cmd   = CMD_W'($urandom_range(0, 3));
          key   = KEY_W'($urandom);
          value = $urandom;
        end else begin
          idx   = $urandom_range(0, 47);
          key   = pool_key[idx];
          value = pool_value[idx];
          roll  = $urandom_range(0, 99);
          if (roll < 38) cmd = CMD_ADD;
          else if (roll < 62) cmd = CMD_DEL;
          else if (roll < 96) cmd = CMD_LOOK;
          else cmd = CMD_UNUSED;
          if ($urandom_range(0, 99) < 12)
            value = value ^ (32'd1 << $urandom_range(0, DHT_VALUE_WIDTH - 1));
        end
        send_request(cmd, key, value);
      end
      if ($urandom_range(0, 2) == 0) wait_idle();
    end
    no_gaps   = 1'b0;
    no_stalls = 1'b0;
    wait_idle();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cmd           = CMD_ADD;
    in_entry_key     = '0;
    in_entry_value   = '0;
    no_gaps          = 1'b0;
    no_stalls        = 1'b0;
    hold_off_request = 0;
    fail_count       = 0;
    results_checked  = 0;
    add_count        = 0;
    delete_count     = 0;
    lookup_count     = 0;
    unused_count     = 0;
    success_count    = 0;
    exhausted_count  = 0;
    for (int i = 0; i < DHT_TABLE_SIZE; i++) begin
      model_live[i] = 1'b0;
      model_tomb[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The block clears its slot flags after reset; send_request simply waits for
    // in_ready, so no fixed delay is needed here.
    test_basic_ops();
    test_tombstone_duplicate();
    test_crowded_class();
    test_result_backpressure();
    test_random_traffic(9);

    // Any stray result would show up as unexpected during this window.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d add, %0d delete, %0d lookup, %0d unused code); %0d results checked.",
             add_count + delete_count + lookup_count + unused_count, add_count, delete_count,
             lookup_count, unused_count, results_checked);
    $display("%0d requests succeeded, %0d probes ran their whole sequence, %0d failures in %0d cycles.",
             success_count, exhausted_count, fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
